// ===== hw/rtl/necir_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necir_pkg
// Shared types and constants for the NEC infrared key decoder.
// ----------------------------------------------------------------------------
package necir_pkg;

  localparam int GAP_W = 32;
  localparam int POS_W = 6;

  // Gap windows in microseconds, all bounds exclusive
  localparam logic [GAP_W-1:0] LEAD_LO   = 32'd13000;
  localparam logic [GAP_W-1:0] LEAD_HI   = 32'd14000;
  localparam logic [GAP_W-1:0] RPT_LO    = 32'd11000;
  localparam logic [GAP_W-1:0] RPT_HI    = 32'd12000;
  localparam logic [GAP_W-1:0] ZERO_LO   = 32'd1000;
  localparam logic [GAP_W-1:0] ZERO_HI   = 32'd1500;
  localparam logic [GAP_W-1:0] ONE_LO    = 32'd2000;
  localparam logic [GAP_W-1:0] ONE_HI    = 32'd2500;

  localparam logic [POS_W-1:0] FRAME_EDGES   = 6'd34;
  localparam logic [POS_W-1:0] FIRST_CMD_POS = 6'd18;
  localparam logic [POS_W-1:0] END_CMD_POS   = 6'd26;
  localparam logic [POS_W-1:0] LEAD_POS      = 6'd1;

  localparam int TABLE_LEN = 10;
  localparam logic [7:0] KEY_TABLE [TABLE_LEN] = '{
    8'h16, 8'h0C, 8'h18, 8'h5E, 8'h08, 8'h1C, 8'h5A, 8'h42, 8'h52, 8'h4A
  };

  typedef enum logic [1:0] {
    CLS_ZERO  = 2'd0,
    CLS_ONE   = 2'd1,
    CLS_OTHER = 2'd2
  } bit_class_t;

  typedef enum logic {
    EV_FRAME  = 1'b0,
    EV_REPEAT = 1'b1
  } event_kind_t;

  typedef struct packed {
    logic       found;
    logic [3:0] index;
  } key_match_t;

endpackage

// ===== hw/rtl/nec_ir_key_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nec_ir_key_decoder_top
// Decodes NEC remote frames from falling-edge timestamps into key events.
//
//   channel  dir  tdata (low bit up)                           tuser
//   in_      in   edge_time[31:0]                              -
//   out_     out  key_index[3:0], key_found, command_byte, 0s  event_kind
//
// One edge is accepted per cycle unless the result register stalls. An
// accepted edge is held in the input register, then the gap compare, bit
// store and table match run in a single pass into the result register.
// Reset clears the edge position, last timestamp, command byte and key.
// A stalled result register holds the input register, which throttles in_.
// ----------------------------------------------------------------------------
module nec_ir_key_decoder_top
  import necir_pkg::*;
#(
  parameter int KEY_COUNT = 10,
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // edge_time[31:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // key_index[3:0], key_found[4], command_byte[12:5]
  output logic [0:0]  out_tuser   // event_kind[0]
);

  // input register
  logic        in_vld_r;
  logic [31:0] in_time_r;

  // decoder state
  logic [TIME_BITS-1:0] prev_time_r, prev_time_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  bit_class_t           class_r [8];
  logic [7:0]           cmd_r, cmd_nxt;
  logic [3:0]           key_r, key_nxt;

  // result register
  logic        out_vld_r;
  event_kind_t out_kind_r;
  logic [3:0]  out_key_r;
  logic        out_found_r;
  logic [7:0]  out_cmd_r;

  logic                 fire;
  logic [TIME_BITS-1:0] gap_raw;
  logic [GAP_W-1:0]     gap;
  logic                 has_gap, lead, rpt, data_slot, done;
  logic [POS_W-1:0]     pos_base, pos_inc;
  logic [2:0]           slot_idx;
  bit_class_t           gap_class;
  logic [7:0]           frame_cmd;
  key_match_t           match;

  assign fire      = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || fire;

  assign gap_raw = in_time_r[TIME_BITS-1:0] - prev_time_r;
  assign gap     = GAP_W'(gap_raw);
  assign has_gap = (pos_r != '0);
  assign lead    = has_gap && (gap > LEAD_LO) && (gap < LEAD_HI);
  assign rpt     = has_gap && !lead && (gap > RPT_LO) && (gap < RPT_HI);

  assign data_slot = has_gap && !lead && !rpt &&
                     (pos_r >= FIRST_CMD_POS) && (pos_r < END_CMD_POS);
  assign slot_idx  = 3'(pos_r - FIRST_CMD_POS);

  always_comb begin
    priority if ((gap > ZERO_LO) && (gap < ZERO_HI)) begin
      gap_class = CLS_ZERO;
    end else if ((gap > ONE_LO) && (gap < ONE_HI)) begin
      gap_class = CLS_ONE;
    end else begin
      gap_class = CLS_OTHER;
    end
  end

  assign pos_base = lead ? LEAD_POS : pos_r;
  assign pos_inc  = pos_base + 6'd1;
  assign done     = !rpt && (pos_inc >= FRAME_EDGES);

  // an unclassified bit keeps last frame's value
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      unique case (class_r[i])
        CLS_ZERO: frame_cmd[i] = 1'b0;
        CLS_ONE:  frame_cmd[i] = 1'b1;
        default:  frame_cmd[i] = cmd_r[i];
      endcase
    end
  end

  necir_key_lookup #(
    .KEY_COUNT (KEY_COUNT)
  ) u_lookup (
    .cmd      (frame_cmd),
    .held_key (key_r),
    .match    (match)
  );

  always_comb begin
    prev_time_nxt = in_time_r[TIME_BITS-1:0];
    pos_nxt       = (rpt || done) ? '0 : pos_inc;
    cmd_nxt       = done ? frame_cmd : cmd_r;
    key_nxt       = done ? match.index : key_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
      prev_time_r <= '0;
      pos_r       <= '0;
      cmd_r       <= '0;
      key_r       <= '0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (fire) begin
        prev_time_r <= prev_time_nxt;
        pos_r       <= pos_nxt;
        cmd_r       <= cmd_nxt;
        key_r       <= key_nxt;
      end
      if (fire && (rpt || done)) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_time_r <= in_tdata;
    end
    if (fire && data_slot) begin
      class_r[slot_idx] <= gap_class;
    end
    if (fire && (rpt || done)) begin
      out_kind_r  <= rpt ? EV_REPEAT : EV_FRAME;
      out_key_r   <= rpt ? key_r : match.index;
      out_found_r <= done && match.found;
      out_cmd_r   <= rpt ? cmd_r : frame_cmd;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, out_cmd_r, out_found_r, out_key_r};
  assign out_tuser  = out_kind_r;

endmodule

// ===== hw/rtl/necir_key_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necir_key_lookup
// Matches a command byte against the fixed key table; highest index wins,
// the held key passes through on a miss.
// ----------------------------------------------------------------------------
module necir_key_lookup
  import necir_pkg::*;
#(
  parameter int KEY_COUNT = 10
) (
  input  logic [7:0]  cmd,
  input  logic [3:0]  held_key,
  output key_match_t  match
);

  localparam int LIMIT = (KEY_COUNT < TABLE_LEN) ? KEY_COUNT : TABLE_LEN;

  always_comb begin
    match.found = 1'b0;
    match.index = held_key;
    for (int i = 0; i < LIMIT; i++) begin
      if (KEY_TABLE[i] == cmd) begin
        match.found = 1'b1;
        match.index = 4'(i);
      end
    end
  end

endmodule

// ===== verif/nec_ir_key_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nec_ir_key_checker
// Watches the edge and key channels of the NEC key decoder. Every accepted
// edge timestamp is run through a local decoder model, and the key events it
// produces are queued and compared field by field with the events that the
// block delivers.
// ----------------------------------------------------------------------------
module nec_ir_key_checker
  import necir_pkg::*;
#(
  parameter int KEY_COUNT = 10,
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // edge_time[31:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // key_index[3:0], key_found[4], command_byte[12:5]
  input  logic [0:0]  out_tuser,  // event_kind[0]
  output int          errors,
  output int          pending
);

  localparam logic [31:0] TIME_MASK = 32'hFFFF_FFFF >> (32 - TIME_BITS);
  localparam int KEY_LIMIT = (KEY_COUNT < TABLE_LEN) ? KEY_COUNT : TABLE_LEN;
  localparam int PRINT_CAP = 40;

  typedef struct packed {
    event_kind_t kind;
    logic [3:0]  key;
    logic        found;
    logic [7:0]  cmd;
  } key_event_t;

  // decoder model state
  logic [31:0] last_stamp;
  logic [5:0]  frame_pos;
  bit_class_t  bit_cls [8];
  logic [7:0]  cmd_bits;
  logic [3:0]  cur_key;

  key_event_t expected_keys [$];
  int fail_count = 0;
  int queued = 0;

  assign errors  = fail_count;
  assign pending = queued;

  task automatic flag_mismatch(input string msg);
    if (fail_count < PRINT_CAP) $display("%0t ns: key event mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  // Advance the model by one edge; returns 1 when the edge completes an event.
  function automatic bit decode_edge(input logic [31:0] edge_time, output key_event_t ev);
    logic [31:0] stamp;
    logic [31:0] gap;
    logic [5:0]  pos;
    logic [5:0]  slot;
    logic [7:0]  cmd;
    bit          rpt;
    bit          hit;
    stamp = edge_time & TIME_MASK;
    pos   = frame_pos;
    rpt   = 1'b0;
    ev    = '0;
    if (pos != '0) begin
      gap = (stamp - last_stamp) & TIME_MASK;
      if (gap > LEAD_LO && gap < LEAD_HI) begin
        pos = LEAD_POS;
      end else if (gap > RPT_LO && gap < RPT_HI) begin
        rpt = 1'b1;
      end else if (pos >= FIRST_CMD_POS && pos < END_CMD_POS) begin
        slot = pos - FIRST_CMD_POS;
        if (gap > ZERO_LO && gap < ZERO_HI) bit_cls[slot[2:0]] = CLS_ZERO;
        else if (gap > ONE_LO && gap < ONE_HI) bit_cls[slot[2:0]] = CLS_ONE;
        else bit_cls[slot[2:0]] = CLS_OTHER;
      end
    end
    last_stamp = stamp;

    if (rpt) begin
      frame_pos = '0;
      ev.kind   = EV_REPEAT;
      ev.key    = cur_key;
      ev.found  = 1'b0;
      ev.cmd    = cmd_bits;
      return 1'b1;
    end

    pos = pos + 6'd1;
    if (pos < FRAME_EDGES) begin
      frame_pos = pos;
      return 1'b0;
    end

    // full frame: assemble the command byte, keep old bits for odd gaps
    frame_pos = '0;
    cmd = '0;
    for (int i = 0; i < 8; i++) begin
      case (bit_cls[i])
        CLS_ZERO: cmd[i] = 1'b0;
        CLS_ONE:  cmd[i] = 1'b1;
        default:  cmd[i] = cmd_bits[i];
      endcase
    end
    cmd_bits = cmd;
    hit = 1'b0;
    for (int i = 0; i < KEY_LIMIT; i++) begin
      if (KEY_TABLE[i] == cmd) begin
        cur_key = 4'(i);
        hit = 1'b1;
      end
    end
    ev.kind  = EV_FRAME;
    ev.key   = cur_key;
    ev.found = hit;
    ev.cmd   = cmd_bits;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    key_event_t ev;
    key_event_t want;
    key_event_t got;
    if (!rst_n) begin
      last_stamp = '0;
      frame_pos  = '0;
      cmd_bits   = '0;
      cur_key    = '0;
      for (int i = 0; i < 8; i++) bit_cls[i] = CLS_ZERO;
      expected_keys.delete();
    end else begin
      // compare before queuing so a spurious result is never masked
      if (out_tvalid && out_tready) begin
        got.kind  = event_kind_t'(out_tuser[0]);
        got.key   = out_tdata[3:0];
        got.found = out_tdata[4];
        got.cmd   = out_tdata[12:5];
        if (expected_keys.size() == 0) begin
          flag_mismatch($sformatf("unexpected result tdata=%h tuser=%h", out_tdata, out_tuser));
        end else begin
          want = expected_keys.pop_front();
          if (got.kind != want.kind)
            flag_mismatch($sformatf("event_kind %0d, want %0d", got.kind, want.kind));
          if (got.key != want.key)
            flag_mismatch($sformatf("key_index %0d, want %0d", got.key, want.key));
          if (got.found != want.found)
            flag_mismatch($sformatf("key_found %0d, want %0d", got.found, want.found));
          if (got.cmd != want.cmd)
            flag_mismatch($sformatf("command_byte %h, want %h", got.cmd, want.cmd));
        end
      end
      if (in_tvalid && in_tready) begin
        if (decode_edge(in_tdata, ev)) expected_keys.push_back(ev);
      end
    end
    queued <= expected_keys.size();
  end

endmodule

// ===== verif/nec_ir_key_decoder_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nec_ir_key_decoder_top_test
// Drives edge timestamps into the NEC key decoder: a few directed edges on
// window bounds and timestamp wrap, then mostly well-formed frames and repeat
// codes with random timing and content, mixed with broken frames and noise.
// Both channels stall at random; the checker predicts and compares events.
// ----------------------------------------------------------------------------
module nec_ir_key_decoder_top_test
  import necir_pkg::*;
();

  localparam int KEY_COUNT     = 10;
  localparam int TIME_BITS     = 32;
  localparam int ITEM_TARGET   = 400;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [0:0]  out_tuser;

  int errors;
  int pending;
  int items_sent = 0;
  int stall_cycles = 0;
  bit calm = 1'b0;
  logic [31:0] stamp = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  nec_ir_key_decoder_top #(
    .KEY_COUNT (KEY_COUNT),
    .TIME_BITS (TIME_BITS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  nec_ir_key_checker #(
    .KEY_COUNT (KEY_COUNT),
    .TIME_BITS (TIME_BITS)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .errors     (errors),
    .pending    (pending)
  );

  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 12);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  // Hold the timestamp until the transaction is accepted.
  task automatic send_at(input logic [31:0] t);
    calm = (items_sent >= 150 && items_sent < 250);
    if (!calm && $urandom_range(99) < 12) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= t;
    stamp = t;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_gap(input logic [31:0] gap);
    send_at(stamp + gap);
  endtask

  function automatic logic [31:0] lead_gap();
    return $urandom_range(LEAD_HI - 1, LEAD_LO + 1);
  endfunction

  function automatic logic [31:0] rpt_gap();
    return $urandom_range(RPT_HI - 1, RPT_LO + 1);
  endfunction

  function automatic logic [31:0] bit_gap(input logic one);
    if (one) return $urandom_range(ONE_HI - 1, ONE_LO + 1);
    return $urandom_range(ZERO_HI - 1, ZERO_LO + 1);
  endfunction

  // Gap that is neither a data bit, a lead nor a repeat.
  function automatic logic [31:0] odd_gap();
    case ($urandom_range(0, 11))
      0:       return ZERO_LO;
      1:       return ZERO_HI;
      2:       return ONE_LO;
      3:       return ONE_HI;
      4:       return RPT_LO;
      5:       return RPT_HI;
      6:       return LEAD_LO;
      7:       return LEAD_HI;
      8:       return $urandom_range(ZERO_LO - 1, 0);
      9:       return $urandom_range(ONE_LO - 1, ZERO_HI + 1);
      10:      return $urandom_range(RPT_LO - 1, ONE_HI + 1);
      default: return $urandom_range(32'hFFFF_FFFF, LEAD_HI);
    endcase
  endfunction

  function automatic logic [31:0] noise_gap();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return lead_gap();
      2:       return rpt_gap();
      3:       return bit_gap(1'b0);
      4:       return bit_gap(1'b1);
      default: return odd_gap();
    endcase
  endfunction

  // Start edge, lead, then 32 data bits; bits 16..23 carry the command.
  task automatic send_frame(input logic [7:0] cmd, input int odd_pct);
    logic [31:0] word;
    word = $urandom();
    word[23:16] = cmd;
    send_at($urandom());
    send_gap(lead_gap());
    for (int i = 0; i < 32; i++) begin
      if ($urandom_range(99) < odd_pct) send_gap(odd_gap());
      else send_gap(bit_gap(word[i]));
    end
  endtask

  task automatic send_repeats(input int count);
    for (int i = 0; i < count; i++) begin
      send_gap($urandom_range(200000, LEAD_HI + 1));
      send_gap(rpt_gap());
    end
  endtask

  // Frame cut short, then a repeat or a fresh lead.
  task automatic send_broken_frame();
    int cut;
    cut = $urandom_range(31, 1);
    send_at($urandom());
    send_gap(lead_gap());
    for (int i = 0; i < cut; i++) send_gap(bit_gap(1'($urandom_range(1))));
    if ($urandom_range(1)) send_gap(rpt_gap());
    else send_gap(lead_gap());
  endtask

  initial begin
    int pick;
    logic [7:0] cmd;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // first edge after reset, then a repeat across the timestamp wrap
    send_at(32'hFFFF_F000);
    send_gap(32'd11500);
    send_at(32'h0000_0000);
    send_at(32'hFFFF_FFFF);
    send_gap(LEAD_LO + 1);
    send_gap(LEAD_HI - 1);
    // exact window bounds are plain data gaps
    send_gap(LEAD_LO);
    send_gap(LEAD_HI);
    send_gap(RPT_LO);
    send_gap(RPT_HI);
    send_gap(32'd0);
    // repeat in the middle of a frame, then a start edge and another repeat
    send_gap(RPT_LO + 1);
    send_gap(RPT_HI - 1);
    send_gap(RPT_HI - 1);

    // table ends, misses, and a frame made only of odd gaps
    send_frame(KEY_TABLE[0], 0);
    send_frame(KEY_TABLE[TABLE_LEN-1], 0);
    send_frame(8'h00, 0);
    send_frame(8'hFF, 0);
    send_frame(8'($urandom()), 100);
    send_repeats(1);

    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        if ($urandom_range(99) < 60) cmd = KEY_TABLE[$urandom_range(TABLE_LEN - 1)];
        else cmd = 8'($urandom());
        send_frame(cmd, ($urandom_range(99) < 75) ? 0 : $urandom_range(40, 5));
        send_repeats($urandom_range(3));
      end else if (pick < 65) begin
        send_repeats($urandom_range(4, 1));
      end else if (pick < 80) begin
        send_broken_frame();
      end else begin
        repeat ($urandom_range(6, 1)) send_gap(noise_gap());
      end
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== nec_ir_key_decoder_top.f =====
hw/rtl/necir_pkg.sv
hw/rtl/necir_key_lookup.sv
hw/rtl/nec_ir_key_decoder_top.sv
verif/nec_ir_key_checker.sv
verif/nec_ir_key_decoder_top_test.sv
